FILE: rtl/texture_tile_swizzle_stream_top_assert.svh
`ifndef TEXTURE_TILE_SWIZZLE_STREAM_TOP_ASSERT_SVH
`define TEXTURE_TILE_SWIZZLE_STREAM_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TTSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TTSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ttss_pkg.sv
package ttss_pkg;

  localparam int unsigned MaxRowQuadsDef = 128;
  localparam int unsigned TileWords      = 4;
  localparam int unsigned BandRows       = 8;

  localparam logic [7:0] RowQuadsReset = 8'd128;

  localparam logic OpWrite = 1'b0;
  localparam logic OpDrain = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] pixel_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] tile_word;
    logic        band_end;
  } out_item_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic band_end;
  } mem_ctl_t;

endpackage

FILE: rtl/ttss_bank_ram.sv
module ttss_bank_ram #(
  parameter int unsigned AddrWidth = 13
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrWidth-1:0] wr_addr_i,
  input  logic [31:0]          wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AddrWidth-1:0] rd_addr_i,
  output logic [31:0]          rd_data_o
);

  logic [31:0] mem [2**AddrWidth];
  logic [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/ttss_addr_gen.sv
`include "texture_tile_swizzle_stream_top_assert.svh"

module ttss_addr_gen #(
  parameter int unsigned MaxRowQuads = ttss_pkg::MaxRowQuadsDef,
  parameter int unsigned AddrWidth   = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            row_quads_i,
  input  logic                  accept_i,
  input  logic                  op_i,
  output ttss_pkg::mem_ctl_t    ctl_o,
  output logic [AddrWidth-1:0]  rd_addr_o,
  output logic [AddrWidth-1:0]  wr_addr_o
);

  localparam int unsigned RowWords = MaxRowQuads * ttss_pkg::TileWords;
  localparam int unsigned BankWords = RowWords * ttss_pkg::BandRows;
  localparam int unsigned ColWidth = $clog2(RowWords);
  localparam int unsigned PosWidth = $clog2(BankWords);
  localparam int unsigned QuadWidth = $clog2(MaxRowQuads + 1);
  localparam int unsigned CmpWidth = (QuadWidth > 8) ? QuadWidth : 8;
  localparam int unsigned LenWidth = CmpWidth + 6;
  localparam logic [2:0] LastRow = 3'(ttss_pkg::BandRows - 1);

  logic [2:0]          write_row_q, write_row_d;
  logic [ColWidth-1:0] write_col_q, write_col_d;
  logic                write_bank_q, write_bank_d;
  logic [PosWidth-1:0] read_pos_q, read_pos_d;
  logic                rd_full_q, rd_full_d;

  logic [CmpWidth-1:0] quads_ext;
  logic [CmpWidth-1:0] quads_eff;
  logic [LenWidth-1:0] row_len;
  logic [LenWidth-1:0] band_len;
  logic [LenWidth-1:0] col_next;
  logic [LenWidth-1:0] pos_next;
  logic                rd_last;
  logic                rd_en;
  logic                wr_en;
  logic                band_done;
  logic [ColWidth-1:0] rd_col;

  assign quads_ext = CmpWidth'(row_quads_i);

  always_comb begin
    if (quads_ext == '0) begin
      quads_eff = CmpWidth'(1);
    end else if (quads_ext > CmpWidth'(MaxRowQuads)) begin
      quads_eff = CmpWidth'(MaxRowQuads);
    end else begin
      quads_eff = quads_ext;
    end
  end

  assign row_len  = LenWidth'(quads_eff) << 2;
  assign band_len = LenWidth'(quads_eff) << 5;
  assign col_next = LenWidth'(write_col_q) + LenWidth'(1);
  assign pos_next = LenWidth'(read_pos_q) + LenWidth'(1);
  assign rd_last  = pos_next >= band_len;

  assign rd_en     = accept_i && rd_full_q;
  assign wr_en     = accept_i && (op_i == ttss_pkg::OpWrite);
  assign band_done = wr_en && (col_next >= row_len) && (write_row_q == LastRow);

  generate
    if (PosWidth > 5) begin : g_multi_tile
      assign rd_col = {read_pos_q[PosWidth-1:5], read_pos_q[1:0]};
    end else begin : g_single_tile
      assign rd_col = read_pos_q[1:0];
    end
  endgenerate

  assign rd_addr_o = {~write_bank_q, read_pos_q[4:2], rd_col};
  assign wr_addr_o = {write_bank_q, write_row_q, write_col_q};

  assign ctl_o.rd_en    = rd_en;
  assign ctl_o.wr_en    = wr_en;
  assign ctl_o.band_end = rd_en && rd_last;

  always_comb begin
    write_row_d  = write_row_q;
    write_col_d  = write_col_q;
    write_bank_d = write_bank_q;
    read_pos_d   = read_pos_q;
    rd_full_d    = rd_full_q;
    if (rd_en) begin
      if (rd_last) begin
        read_pos_d = '0;
        rd_full_d  = 1'b0;
      end else begin
        read_pos_d = pos_next[PosWidth-1:0];
      end
    end
    if (wr_en) begin
      if (col_next >= row_len) begin
        write_col_d = '0;
        if (write_row_q == LastRow) begin
          write_row_d  = '0;
          write_bank_d = ~write_bank_q;
          read_pos_d   = '0;
          rd_full_d    = 1'b1;
        end else begin
          write_row_d = write_row_q + 3'd1;
        end
      end else begin
        write_col_d = col_next[ColWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_row_q  <= '0;
      write_col_q  <= '0;
      write_bank_q <= 1'b0;
      read_pos_q   <= '0;
      rd_full_q    <= 1'b0;
    end else begin
      write_row_q  <= write_row_d;
      write_col_q  <= write_col_d;
      write_bank_q <= write_bank_d;
      read_pos_q   <= read_pos_d;
      rd_full_q    <= rd_full_d;
    end
  end

  `TTSS_ASSERT_NOW(a_bank_split, rd_en && wr_en, rd_addr_o[AddrWidth-1] != wr_addr_o[AddrWidth-1], "read and write hit the same bank")
  `TTSS_ASSERT_NEXT(a_band_swap, band_done, rd_full_q && (read_pos_q == '0), "completed band not pending")

endmodule

FILE: rtl/texture_tile_swizzle_stream_top.sv
// Texture tile swizzle stream: raster-order 32-bit words in, 16-byte by 8-row
// tiled order out.
// Input channel: in_valid_i / in_stall_o with in_item_i (op, pixel_word).
// A write op stores one raster word; a drain op only pulls one output word.
// Every transfer in yields one transfer out while a finished band is pending,
// and nothing otherwise. Output: out_valid_o / out_stall_i with out_item_o;
// band_end marks the last word of each 8-row band.
// Config: cfg_valid_i / cfg_ready_o / cfg_data_i writes row_quads (row width
// in 16-byte groups); write it only while the block is idle.
// An input transfer reaches the output through the synchronous band memory
// read stage and then the output register.
// Throughput: one item per cycle while not stalled; each item does at most
// one write and one read, on separate ports into opposite ping-pong banks.
// Reset clears positions and the pending flag, row_quads returns to 128;
// the band memory is not cleared. When the receiver stalls, one result sits
// in the output register and one in the memory read stage; input is stalled
// only once both are occupied.
`include "texture_tile_swizzle_stream_top_assert.svh"

module texture_tile_swizzle_stream_top #(
  parameter int unsigned MaxRowQuads = ttss_pkg::MaxRowQuadsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ttss_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ttss_pkg::out_item_t out_item_o
);

  localparam int unsigned RowWords = MaxRowQuads * ttss_pkg::TileWords;
  localparam int unsigned AddrWidth = 1 + 3 + $clog2(RowWords);

  logic [7:0]          row_quads_q;
  logic                s1_valid_q, s1_end_q;
  logic                out_valid_q;
  ttss_pkg::out_item_t out_q;

  logic                 accept;
  logic                 out_free;
  logic                 s1_free;
  logic                 s1_move;
  ttss_pkg::mem_ctl_t   ctl;
  logic [AddrWidth-1:0] rd_addr;
  logic [AddrWidth-1:0] wr_addr;
  logic [31:0]          rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_quads_q <= ttss_pkg::RowQuadsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      row_quads_q <= cfg_data_i;
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;

  ttss_addr_gen #(
    .MaxRowQuads(MaxRowQuads),
    .AddrWidth  (AddrWidth)
  ) u_addr_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .row_quads_i(row_quads_q),
    .accept_i   (accept),
    .op_i       (in_item_i.op),
    .ctl_o      (ctl),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr)
  );

  ttss_bank_ram #(
    .AddrWidth(AddrWidth)
  ) u_bank_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ctl.wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(in_item_i.pixel_word),
    .rd_en_i  (ctl.rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= ctl.rd_en;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_end_q <= ctl.band_end;
    end
    if (s1_move) begin
      out_q.tile_word <= rd_data;
      out_q.band_end  <= s1_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `TTSS_ASSERT_NEXT(a_s1_hold, s1_valid_q && !out_free, s1_valid_q, "read stage result dropped")
  `TTSS_ASSERT_NEXT(a_rd_data_hold, s1_valid_q && !out_free, $stable(rd_data), "read data lost while held")
  `TTSS_ASSERT_NOW(a_no_accept_full, s1_valid_q && !out_free, !accept, "transfer accepted with pipeline full")

endmodule

FILE: dv/texture_tile_swizzle_stream_top_tb.sv
module texture_tile_swizzle_stream_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RowWords   = ttss_pkg::MaxRowQuadsDef * ttss_pkg::TileWords;
  localparam int unsigned BankWords  = ttss_pkg::BandRows * RowWords;
  localparam int unsigned StoreWords = 2 * BankWords;

  typedef enum logic {PlanXfer, PlanCfg} plan_kind_e;
  typedef enum logic [1:0] {StallNone, StallSparse, StallToggle, StallHeavy} stall_mode_e;

  typedef struct packed {
    plan_kind_e  kind;
    logic        op;
    logic [31:0] word;
    logic [15:0] reps;
    logic        lit;
    logic [31:0] lit_word;
    logic        lit_end;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [7:0]          cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  ttss_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  ttss_pkg::out_item_t out_item_o;

  logic [31:0] tile_mem [StoreWords];
  bit          tile_mem_written [StoreWords];
  logic [7:0]  quads_reg;
  logic [2:0]  wr_row;
  logic [8:0]  wr_col;
  logic        wr_bank;
  logic [11:0] rd_pos;
  logic        band_ready;

  ttss_pkg::out_item_t tile_words_due [$];
  plan_row_t           plan [22];
  int unsigned         burst_left;
  int unsigned         n_counted;
  int unsigned         n_results;
  int                  errors;

  texture_tile_swizzle_stream_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int unsigned eff_quads(input logic [7:0] q);
    if (q == 8'd0) return 1;
    if (q > ttss_pkg::MaxRowQuadsDef) return ttss_pkg::MaxRowQuadsDef;
    return 32'(q);
  endfunction

  function automatic void advance_swizzle(input ttss_pkg::in_item_t it, output bit has,
                                          output ttss_pkg::out_item_t res);
    int unsigned row_len, band_len, k, tile, row, col, addr;
    row_len  = eff_quads(quads_reg) * ttss_pkg::TileWords;
    band_len = row_len * ttss_pkg::BandRows;
    has = 1'b0;
    res = '0;
    if (band_ready) begin
      k    = 32'(rd_pos);
      tile = k / (ttss_pkg::TileWords * ttss_pkg::BandRows);
      row  = (k / ttss_pkg::TileWords) % ttss_pkg::BandRows;
      col  = tile * ttss_pkg::TileWords + k % ttss_pkg::TileWords;
      addr = (wr_bank ? 0 : BankWords) + row * RowWords + col;
      res.tile_word = tile_mem[addr];
      res.band_end  = (k + 1 >= band_len);
      has = 1'b1;
      if (res.band_end) begin
        rd_pos     = '0;
        band_ready = 1'b0;
      end else begin
        rd_pos = 12'(k + 1);
      end
    end
    if (it.op == ttss_pkg::OpWrite) begin
      addr = (wr_bank ? BankWords : 0) + wr_row * RowWords + wr_col;
      tile_mem[addr]         = it.pixel_word;
      tile_mem_written[addr] = 1'b1;
      if (wr_col + 1 >= row_len) begin
        wr_col = '0;
        if (wr_row + 1 >= ttss_pkg::BandRows) begin
          wr_row     = '0;
          wr_bank    = ~wr_bank;
          rd_pos     = '0;
          band_ready = 1'b1;
        end else begin
          wr_row = wr_row + 3'd1;
        end
      end else begin
        wr_col = wr_col + 9'd1;
      end
    end
  endfunction

  // A wider row is safe only if every word it can read back was stored once.
  function automatic bit widen_ok(input logic [7:0] q);
    int unsigned words, r, c, rd_base, wr_base;
    words   = eff_quads(q) * ttss_pkg::TileWords;
    rd_base = wr_bank ? 0 : BankWords;
    wr_base = wr_bank ? BankWords : 0;
    for (r = 0; r < ttss_pkg::BandRows; r++) begin
      for (c = 0; c < words; c++) begin
        if (band_ready && !tile_mem_written[rd_base + r * RowWords + c]) return 1'b0;
        if (r < wr_row && !tile_mem_written[wr_base + r * RowWords + c]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic int unsigned next_burst();
    if ($urandom_range(0, 3) == 0) return $urandom_range(40, 150);
    return $urandom_range(1, 10);
  endfunction

  task automatic transfer_item(input ttss_pkg::in_item_t it, input bit lit,
                               input ttss_pkg::out_item_t lit_res);
    bit                  has;
    ttss_pkg::out_item_t res;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    advance_swizzle(it, has, res);
    if (lit) tile_words_due.push_back(lit_res);
    else if (has) tile_words_due.push_back(res);
    if (it.op == ttss_pkg::OpWrite || has) n_counted++;
    burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = next_burst();
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (tile_words_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_row_quads(input logic [7:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    quads_reg = value;
  endtask

  task automatic random_item();
    ttss_pkg::in_item_t it;
    it.op         = ($urandom_range(0, 7) == 0) ? ttss_pkg::OpDrain : ttss_pkg::OpWrite;
    it.pixel_word = $urandom();
    transfer_item(it, 1'b0, '0);
  endtask

  // Complete the band being written, then drain the pending band.
  task automatic flush_band();
    ttss_pkg::in_item_t it;
    it.op = ttss_pkg::OpWrite;
    while (wr_row != 0 || wr_col != 0) begin
      it.pixel_word = $urandom();
      transfer_item(it, 1'b0, '0);
    end
    it.op         = ttss_pkg::OpDrain;
    it.pixel_word = $urandom();
    while (band_ready) transfer_item(it, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    ttss_pkg::out_item_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (tile_words_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, tile_word %h band_end %b", $time,
                 out_item_o.tile_word, out_item_o.band_end);
      end else begin
        due = tile_words_due.pop_front();
        if (out_item_o.tile_word !== due.tile_word) begin
          errors++;
          $display("%0t: tile_word expected %h actual %h", $time, due.tile_word,
                   out_item_o.tile_word);
        end
        if (out_item_o.band_end !== due.band_end) begin
          errors++;
          $display("%0t: band_end expected %b actual %b", $time, due.band_end,
                   out_item_o.band_end);
        end
      end
    end
  end

  initial begin
    int unsigned span;
    stall_mode_e mode;
    bit          held;
    out_stall_i <= 1'b0;
    span = 0;
    mode = StallNone;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (!held && n_results >= 300 && in_valid_i) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
      end else begin
        if (span == 0) begin
          span = $urandom_range(10, 80);
          mode = stall_mode_e'($urandom_range(0, 3));
        end
        span--;
        case (mode)
          StallNone:   out_stall_i <= 1'b0;
          StallSparse: out_stall_i <= ($urandom_range(0, 2) == 0);
          StallToggle: out_stall_i <= ~out_stall_i;
          default:     out_stall_i <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    ttss_pkg::in_item_t  it;
    ttss_pkg::out_item_t lit_res;
    int unsigned         cand;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    quads_reg   = ttss_pkg::RowQuadsReset;
    wr_row      = '0;
    wr_col      = '0;
    wr_bank     = 1'b0;
    rd_pos      = '0;
    band_ready  = 1'b0;
    n_counted   = 0;
    n_results   = 0;
    errors      = 0;
    burst_left  = next_burst();
    plan = '{
      '{PlanXfer, ttss_pkg::OpDrain, 32'h0000_0000, 16'd1,  1'b0, 32'h0000_0000, 1'b0},
      '{PlanCfg,  ttss_pkg::OpWrite, 32'h0000_0002, 16'd1,  1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpWrite, 32'hFFFF_FFFF, 16'd1,  1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpWrite, 32'h0000_0000, 16'd1,  1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpDrain, 32'h0000_0000, 16'd1,  1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpWrite, 32'h0000_0100, 16'd61, 1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpWrite, 32'hC000_0000, 16'd1,  1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpWrite, 32'h8000_0000, 16'd1,  1'b1, 32'hFFFF_FFFF, 1'b0},
      '{PlanXfer, ttss_pkg::OpDrain, 32'h0000_0000, 16'd1,  1'b1, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpWrite, 32'h0000_0200, 16'd60, 1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpDrain, 32'h0000_0000, 16'd1,  1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpWrite, 32'h7FFF_FFFF, 16'd1,  1'b1, 32'hC000_0000, 1'b1},
      '{PlanXfer, ttss_pkg::OpWrite, 32'h5A5A_5A5A, 16'd1,  1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpWrite, 32'hA5A5_A5A5, 16'd1,  1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpWrite, 32'h0000_0400, 16'd20, 1'b0, 32'h0000_0000, 1'b0},
      '{PlanCfg,  ttss_pkg::OpWrite, 32'h0000_0000, 16'd1,  1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpWrite, 32'h0000_0500, 16'd21, 1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpWrite, 32'h0000_0600, 16'd4,  1'b0, 32'h0000_0000, 1'b0},
      '{PlanCfg,  ttss_pkg::OpWrite, 32'h0000_0002, 16'd1,  1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpWrite, 32'h0000_0700, 16'd56, 1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpDrain, 32'h0000_0000, 16'd64, 1'b0, 32'h0000_0000, 1'b0},
      '{PlanXfer, ttss_pkg::OpDrain, 32'h0000_0000, 16'd1,  1'b0, 32'h0000_0000, 1'b0}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 22; i++) begin
      if (plan[i].kind == PlanCfg) begin
        write_row_quads(plan[i].word[7:0]);
      end else begin
        for (int j = 0; j < plan[i].reps; j++) begin
          it.op             = plan[i].op;
          it.pixel_word     = plan[i].word + j;
          lit_res.tile_word = plan[i].lit_word;
          lit_res.band_end  = plan[i].lit_end;
          transfer_item(it, plan[i].lit, lit_res);
        end
      end
    end

    while (n_counted < 800) begin
      if ($urandom_range(0, 2) == 0) flush_band();
      cand = $urandom_range(0, 8);
      if (eff_quads(cand[7:0]) > eff_quads(quads_reg) && !widen_ok(cand[7:0])) begin
        cand = $urandom_range(0, eff_quads(quads_reg));
      end
      write_row_quads(cand[7:0]);
      repeat ($urandom_range(20, 250)) random_item();
    end

    // Wrap one full-width row, then narrow and finish the band.
    flush_band();
    write_row_quads(8'd255);
    it.op = ttss_pkg::OpWrite;
    repeat (RowWords + 8) begin
      it.pixel_word = $urandom();
      transfer_item(it, 1'b0, '0);
    end
    write_row_quads(8'd2);
    flush_band();
    write_row_quads(8'd0);
    repeat (150) random_item();

    settle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
